// File: rtl/core/mms_pkg.sv
`default_nettype none

package mms_pkg;

    // Line buffer depth: widest row the block can hold.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths.
    localparam int VAL_W   = 16;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 12;
    localparam int ROW_W   = HGT_W + 1;
    localparam int EW_W    = ($clog2(MAX_WIDTH + 1) > WID_W) ? $clog2(MAX_WIDTH + 1) : WID_W;

    // Datapath widths of the window sum and the division by the count.
    localparam int SUM3_W    = VAL_W + 2;
    localparam int SUM_W     = VAL_W + 4;
    localparam int CNT3_W    = 2;
    localparam int CNT_W     = 4;
    localparam int RCP_SHIFT = 24;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RCP_W;

    // Configuration port.
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int IDX_LSB = 2;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(1024);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(1024);

    // One stored pixel: value plus its valid flag.
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
    } t_pix;

    // Which window rows and columns lie inside the frame for one result.
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_edge;

    // Rounded-up reciprocal of the valid count, scaled by 2^RCP_SHIFT.
    // Exact floor division for every window sum below 2^SUM_W.
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        case (cnt)
            4'd1:    r = RCP_W'(16777216);
            4'd2:    r = RCP_W'(8388608);
            4'd3:    r = RCP_W'(5592406);
            4'd4:    r = RCP_W'(4194304);
            4'd5:    r = RCP_W'(3355444);
            4'd6:    r = RCP_W'(2796203);
            4'd7:    r = RCP_W'(2396746);
            4'd8:    r = RCP_W'(2097152);
            4'd9:    r = RCP_W'(1864136);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mms_if.sv
`default_nettype none

// Pixel stream into the smoother.
interface mms_in_if;
    logic                      valid;
    logic                      ready;
    logic [mms_pkg::VAL_W-1:0] pixel_value;
    logic                      pixel_valid;
    logic                      flush;

    modport source (output valid, pixel_value, pixel_valid, flush, input ready);
    modport sink   (input valid, pixel_value, pixel_valid, flush, output ready);
endinterface

// Smoothed result stream.
interface mms_out_if;
    logic                      valid;
    logic                      ready;
    logic [mms_pkg::VAL_W-1:0] mean_value;
    logic                      mean_valid;
    logic                      frame_last;

    modport source (output valid, mean_value, mean_valid, frame_last, input ready);
    modport sink   (input valid, mean_value, mean_valid, frame_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/masked_3x3_mean_smoother.sv
// Throughput: one pixel transfer per cycle; a stalled output stalls the whole pipeline.
// A result passes through the pipeline stage registers after the transfer of the item that completes its
// window, which comes W+1 items after the pixel itself (W+1 flush items drain a frame).
// Reset (i_rst_n low at a clock edge) clears position, window and pipeline and sets both
// frame registers to 1024; the two line memories are not cleared and need no clearing pass.
`default_nettype none

module masked_3x3_mean_smoother (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mms_in_if.sink                      i_pix,
    mms_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mms_pkg::ADDR_W-1:0]  paddr,
    input  logic [mms_pkg::DATA_W-1:0]  pwdata,
    output logic [mms_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mms_pkg::*;

    // Configuration registers.
    logic [WID_W-1:0] r_fw;
    logic [HGT_W-1:0] r_fh;
    logic             cfg_wr;
    logic             cfg_idx;
    logic [EW_W-1:0]  w_eff;
    logic [HGT_W-1:0] h_eff;

    // Position counters.
    logic [COL_W-1:0] r_col, n_col;
    logic [HGT_W-1:0] r_row, n_row;
    logic             r_drain, n_drain;
    logic             r_tail, n_tail;
    logic             r_sel, n_sel;

    // Input stage.
    logic             en;
    logic             fire;
    logic             proc;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [ROW_W-1:0] h_ext;
    logic             c_zero;
    logic             col_end;
    logic             row_end;
    logic             has_res;
    t_edge            n_edge;
    t_pix             n_pix;

    // Line memories: line[r_sel] holds row r-2, the other holds row r-1.
    t_pix             r_line0 [MAX_WIDTH];
    t_pix             r_line1 [MAX_WIDTH];
    t_pix             r_rd0, r_rd1;

    // Stage 1.
    logic             r_s1_v;
    logic             r_s1_res;
    t_edge            r_s1_edge;
    t_pix             r_s1_nv;
    logic             r_s1_sel;
    t_pix             above2, above1;

    // Stage 2: the window itself.
    t_pix [2:0][2:0]  r_win;
    logic             r_s2_v;
    t_edge            r_s2_edge;
    logic [2:0]       row_ok, col_ok;
    logic [2:0][SUM3_W-1:0] n_csum;
    logic [2:0][CNT3_W-1:0] n_ccnt;

    // Stage 3.
    logic             r_s3_v;
    logic             r_s3_last;
    logic [2:0][SUM3_W-1:0] r_s3_csum;
    logic [2:0][CNT3_W-1:0] r_s3_ccnt;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;

    // Stage 4.
    logic             r_s4_v;
    logic             r_s4_last;
    logic             r_s4_nz;
    logic [SUM_W-1:0] r_s4_sum;
    logic [RCP_W-1:0] r_s4_rcp;
    logic [PROD_W-1:0] n_prod;

    // Stage 5: output register.
    logic             r_s5_v;
    logic [VAL_W-1:0] r_s5_mean;
    logic             r_s5_nz;
    logic             r_s5_last;

    // APB port: a write completes in its access cycle.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[IDX_LSB];
    assign prdata  = (cfg_idx == REG_FRAME_HEIGHT) ? DATA_W'(r_fh) : DATA_W'(r_fw);

    // Effective frame size: zero acts as one, width clamps to the line depth.
    always_comb begin
        if (r_fw == '0) begin
            w_eff = EW_W'(1);
        end else if (EW_W'(r_fw) > EW_W'(MAX_WIDTH)) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(r_fw);
        end
        h_eff = (r_fh == '0) ? HGT_W'(1) : r_fh;
    end

    // Handshake: the pipeline moves whenever the output register can take a result.
    assign en           = !r_s5_v || o_res.ready;
    assign i_pix.ready  = en;
    assign fire         = i_pix.valid && en;
    assign proc         = fire && (r_drain || !i_pix.flush);

    // Position of the current item; the drain runs row H and one item of row H+1.
    assign h_ext   = ROW_W'(h_eff);
    assign c_cur   = r_tail ? '0 : r_col;
    assign r_cur   = r_tail ? (h_ext + ROW_W'(1)) : (r_drain ? h_ext : ROW_W'(r_row));
    assign c_zero  = (c_cur == '0);
    assign col_end = (EW_W'(r_col) + EW_W'(1)) >= w_eff;
    assign row_end = (ROW_W'(r_row) + ROW_W'(1)) >= h_ext;

    // Window center and its frame edges; column zero completes the previous row.
    always_comb begin
        has_res         = c_zero ? (r_cur >= ROW_W'(2)) : (r_cur >= ROW_W'(1));
        n_edge.top_ok   = c_zero ? (r_cur >= ROW_W'(3)) : (r_cur >= ROW_W'(2));
        n_edge.bot_ok   = c_zero ? (r_cur <= h_ext) : (r_cur < h_ext);
        n_edge.left_ok  = c_zero ? (w_eff >= EW_W'(2)) : (c_cur >= COL_W'(2));
        n_edge.right_ok = !c_zero;
        n_edge.last     = r_tail;
        n_pix.valid     = !r_drain && i_pix.pixel_valid;
        n_pix.value     = n_pix.valid ? i_pix.pixel_value : '0;
    end

    // Next position after a processed item.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_tail  = r_tail;
        n_sel   = r_sel;
        if (proc) begin
            if (r_tail) begin
                n_col   = '0;
                n_row   = '0;
                n_drain = 1'b0;
                n_tail  = 1'b0;
                n_sel   = ~r_sel;
            end else if (col_end) begin
                n_col = '0;
                n_sel = ~r_sel;
                if (r_drain) begin
                    n_tail = 1'b1;
                end else if (row_end) begin
                    n_row   = '0;
                    n_drain = 1'b1;
                end else begin
                    n_row = r_row + HGT_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Line memories: read both rows, overwrite the older one at the same column.
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd0 <= r_line0[c_cur];
            r_rd1 <= r_line1[c_cur];
            if (r_sel) begin
                r_line1[c_cur] <= n_pix;
            end else begin
                r_line0[c_cur] <= n_pix;
            end
        end
    end

    assign above2 = r_s1_sel ? r_rd1 : r_rd0;
    assign above1 = r_s1_sel ? r_rd0 : r_rd1;

    // Control state, valid bits and the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= WIDTH_RST;
            r_fh    <= HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= 1'b0;
            r_tail  <= 1'b0;
            r_sel   <= 1'b0;
            r_win   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
        end else if (cfg_wr) begin
            // A register write restarts the frame and drops pending results.
            if (cfg_idx == REG_FRAME_WIDTH) begin
                r_fw <= pwdata[WID_W-1:0];
            end else begin
                r_fh <= pwdata[HGT_W-1:0];
            end
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= 1'b0;
            r_tail  <= 1'b0;
            r_win   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            r_tail  <= n_tail;
            r_sel   <= n_sel;
            if (en) begin
                r_s1_v <= proc;
                r_s2_v <= r_s1_v && r_s1_res;
                r_s3_v <= r_s2_v;
                r_s4_v <= r_s3_v;
                r_s5_v <= r_s4_v;
                // The window shifts by one column for every processed item.
                if (r_s1_v) begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= above2;
                    r_win[1][2] <= above1;
                    r_win[2][2] <= r_s1_nv;
                end
            end
        end
    end

    // Masked column sums over the window.
    assign row_ok = {r_s2_edge.bot_ok, 1'b1, r_s2_edge.top_ok};
    assign col_ok = {r_s2_edge.right_ok, 1'b1, r_s2_edge.left_ok};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_csum[j] = '0;
            n_ccnt[j] = '0;
            for (int i = 0; i < 3; i++) begin
                if (row_ok[i] && col_ok[j] && r_win[i][j].valid) begin
                    n_csum[j] = n_csum[j] + SUM3_W'(r_win[i][j].value);
                    n_ccnt[j] = n_ccnt[j] + CNT3_W'(1);
                end
            end
        end
    end

    // Total sum and count of the valid window pixels.
    assign n_sum = SUM_W'(r_s3_csum[0]) + SUM_W'(r_s3_csum[1]) + SUM_W'(r_s3_csum[2]);
    assign n_cnt = CNT_W'(r_s3_ccnt[0]) + CNT_W'(r_s3_ccnt[1]) + CNT_W'(r_s3_ccnt[2]);

    // Division by the count as a multiply by its reciprocal.
    assign n_prod = PROD_W'(r_s4_sum) * PROD_W'(r_s4_rcp);

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (proc) begin
                r_s1_res  <= has_res;
                r_s1_edge <= n_edge;
                r_s1_nv   <= n_pix;
                r_s1_sel  <= r_sel;
            end
            r_s2_edge <= r_s1_edge;
            r_s3_csum <= n_csum;
            r_s3_ccnt <= n_ccnt;
            r_s3_last <= r_s2_edge.last;
            r_s4_sum  <= n_sum;
            r_s4_rcp  <= recip(n_cnt);
            r_s4_nz   <= (n_cnt != '0);
            r_s4_last <= r_s3_last;
            r_s5_mean <= n_prod[RCP_SHIFT +: VAL_W];
            r_s5_nz   <= r_s4_nz;
            r_s5_last <= r_s4_last;
        end
    end

    // Result transfer.
    assign o_res.valid      = r_s5_v;
    assign o_res.mean_value = r_s5_mean;
    assign o_res.mean_valid = r_s5_nz;
    assign o_res.frame_last = r_s5_last;

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mms_pkg::*;

    localparam int TOTAL_ITEMS   = 1150;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 800_000;
    localparam int MAX_PRINTS    = 30;
    localparam int N_ROWS        = 26;

    // One smoothed pixel as it leaves the block.
    typedef struct packed {
        logic [VAL_W-1:0] mean;
        logic             ok;
        logic             last;
    } t_mean;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_FLUSH, ROW_SET_WIDTH, ROW_SET_HEIGHT} t_row_kind;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    // One line of the directed table; typed rows carry their known result.
    typedef struct {
        t_row_kind   kind;
        int unsigned arg;
        logic        pix_ok;
        bit          typed;
        t_mean       want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mms_in_if  pix_bus ();
    mms_out_if res_bus ();

    masked_3x3_mean_smoother i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Directed frames: 1x1 with valid, invalid and zero pixels, a drain-time
    // pixel, a stray flush, zero-valued registers, and a 2x2 truncating mean.
    t_row directed_rows [N_ROWS] = '{
        '{ROW_SET_WIDTH,  1,     1'b0, 1'b0, '0},
        '{ROW_SET_HEIGHT, 1,     1'b0, 1'b0, '0},
        '{ROW_PIXEL,      65535, 1'b1, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd65535, 1'b1, 1'b1}},
        '{ROW_PIXEL,      65535, 1'b0, 1'b0, '0},
        '{ROW_PIXEL,      1234,  1'b1, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd0, 1'b0, 1'b1}},
        '{ROW_FLUSH,      0,     1'b0, 1'b0, '0},
        '{ROW_PIXEL,      0,     1'b1, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd0, 1'b1, 1'b1}},
        '{ROW_SET_WIDTH,  0,     1'b0, 1'b0, '0},
        '{ROW_SET_HEIGHT, 0,     1'b0, 1'b0, '0},
        '{ROW_PIXEL,      40000, 1'b1, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b0, '0},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd40000, 1'b1, 1'b1}},
        '{ROW_SET_WIDTH,  2,     1'b0, 1'b0, '0},
        '{ROW_SET_HEIGHT, 2,     1'b0, 1'b0, '0},
        '{ROW_PIXEL,      65535, 1'b1, 1'b0, '0},
        '{ROW_PIXEL,      65535, 1'b1, 1'b0, '0},
        '{ROW_PIXEL,      65534, 1'b1, 1'b0, '0},
        '{ROW_PIXEL,      9,     1'b0, 1'b1, '{16'd65534, 1'b1, 1'b0}},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd65534, 1'b1, 1'b0}},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd65534, 1'b1, 1'b0}},
        '{ROW_FLUSH,      0,     1'b0, 1'b1, '{16'd65534, 1'b1, 1'b1}}
    };

    // Predictor state: registers, two line memories, window and position.
    logic [WID_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;
    t_pix             line_mem [2*MAX_WIDTH];
    t_pix             win_regs [3][3];
    int               col_pos;
    int               row_pos;
    int               drain_pos;
    bit               draining;

    t_mean pending_means [$];

    int mismatches      = 0;
    int pixels_in       = 0;
    int means_checked   = 0;
    int lasts_seen      = 0;
    int register_writes = 0;
    int gap_pct         = 0;
    int stall_pct       = 0;
    int hold_asks       = 0;
    int holds_done      = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results still expected.", pending_means.size());
        $display("[masked_3x3_mean_smoother] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Appends one expected mean behind the ones already waiting.
    function automatic void queue_mean(input t_mean m);
        pending_means = {pending_means, m};
    endfunction

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    // A register write restarts the frame; the line memories keep their data.
    function automatic void clear_position();
        foreach (win_regs[i, j]) win_regs[i][j] = '0;
        col_pos   = 0;
        row_pos   = 0;
        drain_pos = 0;
        draining  = 1'b0;
    endfunction

    function automatic void load_register(input logic idx, input logic [DATA_W-1:0] wd);
        if (idx == REG_FRAME_WIDTH) begin
            cfg_width = wd[WID_W-1:0];
        end else begin
            cfg_height = wd[HGT_W-1:0];
        end
        clear_position();
    endfunction

    // Advances the window by one transfer and returns the mean it completes, if any.
    function automatic bit smooth_predict(input logic [VAL_W-1:0] pv, input logic ok,
                                          input logic fl, output t_mean res);
        int          w;
        int          h;
        int          r;
        int          c;
        int          pr;
        int          pc;
        int          yy;
        int          xx;
        int          cnt;
        int unsigned sum;
        bit          in_drain;
        t_pix        nv;
        t_pix        up2;
        t_pix        up1;
        w        = eff_width();
        h        = eff_height();
        res      = '0;
        sum      = 0;
        cnt      = 0;
        in_drain = draining;
        if (!in_drain) begin
            if (fl) return 1'b0;
            r  = row_pos;
            c  = col_pos;
            nv = ok ? {1'b1, pv} : '0;
        end else begin
            if (drain_pos < w) begin
                r = h;
                c = drain_pos;
            end else begin
                r = h + 1;
                c = 0;
            end
            nv = '0;
        end

        // Shift the column of the two stored rows and the new pixel into the window.
        up2 = line_mem[c];
        up1 = line_mem[MAX_WIDTH + c];
        line_mem[c]             = up1;
        line_mem[MAX_WIDTH + c] = nv;
        for (int i = 0; i < 3; i++) begin
            win_regs[i][0] = win_regs[i][1];
            win_regs[i][1] = win_regs[i][2];
        end
        win_regs[0][2] = up2;
        win_regs[1][2] = up1;
        win_regs[2][2] = nv;

        // The window is centered one row and one column behind this transfer.
        if (c >= 1) begin
            pr = r - 1;
            pc = c - 1;
        end else begin
            pr = r - 2;
            pc = w - 1;
        end

        if (!in_drain) begin
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos   = 0;
                    draining  = 1'b1;
                    drain_pos = 0;
                end
            end
        end else begin
            drain_pos++;
            if (drain_pos > w) begin
                draining  = 1'b0;
                drain_pos = 0;
            end
        end

        if (pr < 0) return 1'b0;

        // Average the valid neighbors that lie inside the frame.
        for (int i = 0; i < 3; i++) begin
            yy = pr + i - 1;
            if (yy >= 0 && yy < h) begin
                for (int j = 0; j < 3; j++) begin
                    xx = pc + j - 1;
                    if (xx >= 0 && xx < w && win_regs[i][j].valid) begin
                        sum += win_regs[i][j].value;
                        cnt++;
                    end
                end
            end
        end
        res.mean = (cnt != 0) ? VAL_W'(sum / cnt) : '0;
        res.ok   = (cnt != 0);
        res.last = (pr == h - 1 && pc == w - 1);
        return 1'b1;
    endfunction

    function automatic void set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                gap_pct   = 69;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct   = 0;
                stall_pct = 69;
            end
            default: begin
                gap_pct   = 26;
                stall_pct = 26;
            end
        endcase
    endfunction

    // Extremes come up often so that value bits see both states at the edges.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // One APB transfer: setup, access, then idle with psel low.
    // Starts and ends at a falling edge.
    task automatic apb_access(input logic wr, input logic idx, input logic [DATA_W-1:0] wd,
                              output logic [DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx) << IDX_LSB;
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every expected mean has come out and the pipeline is quiet.
    task automatic settle_block();
        int spent;
        spent = 0;
        pix_bus.valid <= 1'b0;
        while (pending_means.size() != 0 && spent < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spent++;
        end
        if (pending_means.size() != 0) begin
            report_mismatch("results never delivered", pending_means.size(), 0);
            pending_means.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes a frame register with random upper bits, then reads it back.
    task automatic set_register(input logic idx, input int unsigned val);
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] kept;
        settle_block();
        wd = $urandom;
        if (idx == REG_FRAME_WIDTH) begin
            wd[WID_W-1:0] = val[WID_W-1:0];
            kept          = DATA_W'(val[WID_W-1:0]);
        end else begin
            wd[HGT_W-1:0] = val[HGT_W-1:0];
            kept          = DATA_W'(val[HGT_W-1:0]);
        end
        apb_access(1'b1, idx, wd, rd);
        load_register(idx, wd);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== kept) report_mismatch("register readback", rd, kept);
        register_writes++;
    endtask

    // Offers one item after a random gap and records the expected mean it completes once transferred.
    task automatic send_pixel(input logic [VAL_W-1:0] pv, input logic ok, input logic fl,
                              input bit typed = 1'b0, input t_mean want = '0);
        t_mean got;
        bit    made;
        bit    ignored;
        while ($urandom_range(99) < gap_pct) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= pv;
        pix_bus.pixel_valid <= ok;
        pix_bus.flush       <= fl;
        do @(posedge i_clk); while (!pix_bus.ready);
        ignored = fl && !draining;
        made    = smooth_predict(pv, ok, fl, got);
        if (typed) begin
            queue_mean(want);
        end else if (made) begin
            queue_mean(got);
        end
        if (!ignored) pixels_in++;
        @(negedge i_clk);
    endtask

    // Pixels with the odd stray flush, then drain items that are mostly flushes.
    task automatic run_frame(input int n_pix, input int n_drain, input int valid_pct);
        repeat (n_pix) begin
            if ($urandom_range(99) < 4) send_pixel(pick_value(), 1'($urandom_range(1)), 1'b1);
            send_pixel(pick_value(), $urandom_range(99) < valid_pct, 1'b0);
        end
        repeat (n_drain) begin
            send_pixel(pick_value(), 1'($urandom_range(1)), $urandom_range(99) < 85);
        end
    endtask

    // Output side: random stalls, and a long hold-off whenever one is asked for.
    initial begin
        res_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holds_done < hold_asks) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each result transfer with the oldest expected mean.
    always @(posedge i_clk) begin : check_means
        t_mean want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("unexpected result, mean_value", res_bus.mean_value, 0);
            end else begin
                want = pending_means.pop_front();
                if (res_bus.mean_value !== want.mean)
                    report_mismatch("mean_value", res_bus.mean_value, want.mean);
                if (res_bus.mean_valid !== want.ok)
                    report_mismatch("mean_valid", res_bus.mean_valid, want.ok);
                if (res_bus.frame_last !== want.last)
                    report_mismatch("frame_last", res_bus.frame_last, want.last);
            end
            means_checked++;
            if (res_bus.frame_last === 1'b1) lasts_seen++;
        end
    end

    initial begin
        logic [DATA_W-1:0] rd;
        int                w;
        int                h;
        int                k;
        int                vp;
        int                nf;
        int                phase_no;
        bit                cut;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel_value = '0;
        pix_bus.pixel_valid = 1'b0;
        pix_bus.flush       = 1'b0;
        phase_no            = 0;

        cfg_width  = WIDTH_RST;
        cfg_height = HEIGHT_RST;
        foreach (line_mem[i]) line_mem[i] = '0;
        clear_position();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers come out of reset at 1024 x 1024.
        apb_access(1'b0, REG_FRAME_WIDTH, '0, rd);
        if (rd !== DATA_W'(WIDTH_RST)) report_mismatch("frame_width after reset", rd, WIDTH_RST);
        apb_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
        if (rd !== DATA_W'(HEIGHT_RST)) report_mismatch("frame_height after reset", rd, HEIGHT_RST);

        // Part of a frame at the reset size, cut off by the first register write.
        set_idling(IDLE_SENDER);
        run_frame(12, 0, 80);

        // Directed table.
        set_idling(IDLE_BOTH);
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_SET_WIDTH:  set_register(REG_FRAME_WIDTH, directed_rows[i].arg);
                ROW_SET_HEIGHT: set_register(REG_FRAME_HEIGHT, directed_rows[i].arg);
                ROW_FLUSH: begin
                    send_pixel(pick_value(), 1'($urandom_range(1)), 1'b1,
                               directed_rows[i].typed, directed_rows[i].want);
                end
                default: begin
                    send_pixel(VAL_W'(directed_rows[i].arg), directed_rows[i].pix_ok, 1'b0,
                               directed_rows[i].typed, directed_rows[i].want);
                end
            endcase
        end

        // Oversized width value, then a short stretch of a frame that the next write cuts off.
        set_idling(IDLE_NONE);
        set_register(REG_FRAME_WIDTH, 2047);
        set_register(REG_FRAME_HEIGHT, 1);
        run_frame(20, 0, 90);

        // Full 8x8 frame; the output holds off late in the frame so that the block fills.
        set_register(REG_FRAME_WIDTH, 8);
        set_register(REG_FRAME_HEIGHT, 8);
        run_frame(40, 0, 90);
        hold_asks++;
        run_frame(24, 9, 90);

        // Tallest height, one pixel wide, cut short by the next write.
        set_idling(IDLE_RECEIVER);
        set_register(REG_FRAME_WIDTH, 1);
        set_register(REG_FRAME_HEIGHT, 4095);
        run_frame(30, 0, 70);

        // Random settings, mostly small frames, some cut short by the next write.
        while (pixels_in < TOTAL_ITEMS) begin
            set_idling(t_idling'(phase_no % 4));
            phase_no++;
            k = $urandom_range(19);
            w = (k == 0) ? 0 : (k < 16) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            k = $urandom_range(19);
            h = (k == 0) ? 0 : (k < 17) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            set_register(REG_FRAME_WIDTH, w);
            set_register(REG_FRAME_HEIGHT, h);
            w  = eff_width();
            h  = eff_height();
            k  = $urandom_range(9);
            vp = (k == 0) ? 0 : (k < 4) ? 100 : (k < 8) ? 75 : 25;
            nf = $urandom_range(1, 3);
            cut = 1'b0;
            for (int f = 0; f < nf && !cut && pixels_in < TOTAL_ITEMS; f++) begin
                cut = ($urandom_range(11) == 0);
                if (cut) begin
                    run_frame($urandom_range(0, w * h - 1), 0, vp);
                end else begin
                    run_frame(w * h, w + 1, vp);
                end
            end
        end

        settle_block();
        $display("Checked %0d smoothed pixels from %0d pixel transfers over %0d register writes,",
                 means_checked, pixels_in, register_writes);
        $display("with %0d frame ends, widths 0 to 2047, heights 0 to 4095 and a %0d-cycle hold.",
                 lasts_seen, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[masked_3x3_mean_smoother] OK");
        end else begin
            $display("[masked_3x3_mean_smoother] ERROR");
        end
        $finish;
    end

endmodule
